@@ rtl/gfp2_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gfp2_pkg
// Shared width, opcodes, operand slots and stage control type for the
// GF(p^2) field ALU.
// ----------------------------------------------------------------------------
package gfp2_pkg;

  localparam int WIDTH = 64;

  typedef logic [WIDTH-1:0] word_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_SQR  = 3'd3,
    OP_FROB = 3'd4
  } op_e;

  // operand slots
  localparam int IX1 = 0;
  localparam int IX2 = 1;
  localparam int IY1 = 2;
  localparam int IY2 = 3;

  typedef struct packed {
    logic valid;
    op_e  op;
  } ctl_t;

endpackage
`default_nettype wire

@@ rtl/gfp2_reduce.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gfp2_reduce
// Pipelined restoring reduction of four operands mod p, one bit per stage.
// ----------------------------------------------------------------------------
module gfp2_reduce (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire gfp2_pkg::word_t             mod_i,
  input  wire gfp2_pkg::ctl_t              ctl_i,
  input  wire gfp2_pkg::word_t [3:0]       val_i,
  output gfp2_pkg::ctl_t                   ctl_o,
  output gfp2_pkg::word_t [3:0]            res_o
);

  localparam int W = gfp2_pkg::WIDTH;

  gfp2_pkg::ctl_t            ctl_q [W];
  gfp2_pkg::word_t [3:0]     src_q [W];
  gfp2_pkg::word_t [3:0]     rem_q [W];

  for (genvar s = 0; s < W; s++) begin : g_st
    gfp2_pkg::ctl_t        ctl_in;
    gfp2_pkg::word_t [3:0] src_in;
    gfp2_pkg::word_t [3:0] rem_in;
    gfp2_pkg::word_t [3:0] rem_d;

    if (s == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign src_in = val_i;
      assign rem_in = '0;
    end else begin : g_next
      assign ctl_in = ctl_q[s-1];
      assign src_in = src_q[s-1];
      assign rem_in = rem_q[s-1];
    end

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        logic [W:0] sh;
        sh = {rem_in[l], src_in[l][W-1-s]};
        if (sh >= {1'b0, mod_i}) begin
          rem_d[l] = W'(sh - {1'b0, mod_i});
        end else begin
          rem_d[l] = sh[W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '{valid: 1'b0, op: gfp2_pkg::OP_ADD};
      end else begin
        ctl_q[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      src_q[s]    <= src_in;
      rem_q[s]    <= rem_d;
    end
  end

  assign ctl_o = ctl_q[W-1];
  assign res_o = rem_q[W-1];

endmodule
`default_nettype wire

@@ rtl/gfp2_mulmod.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gfp2_mulmod
// Four pipelined double-and-add modular multipliers, one multiplier bit per
// stage. Operands travel along for the final combine.
// ----------------------------------------------------------------------------
module gfp2_mulmod (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire gfp2_pkg::word_t             mod_i,
  input  wire gfp2_pkg::ctl_t              ctl_i,
  input  wire gfp2_pkg::word_t [3:0]       val_i,
  output gfp2_pkg::ctl_t                   ctl_o,
  output gfp2_pkg::word_t [3:0]            val_o,
  output gfp2_pkg::word_t [3:0]            prod_o
);

  localparam int W = gfp2_pkg::WIDTH;
  // products: x1*y2, x2*y1, x2*y2, x1*y1
  localparam int LA [4] = '{gfp2_pkg::IX1, gfp2_pkg::IX2, gfp2_pkg::IX2, gfp2_pkg::IX1};
  localparam int LB [4] = '{gfp2_pkg::IY2, gfp2_pkg::IY1, gfp2_pkg::IY2, gfp2_pkg::IY1};

  gfp2_pkg::ctl_t            ctl_q [W];
  gfp2_pkg::word_t [3:0]     val_q [W];
  gfp2_pkg::word_t [3:0]     acc_q [W];

  for (genvar s = 0; s < W; s++) begin : g_st
    gfp2_pkg::ctl_t        ctl_in;
    gfp2_pkg::word_t [3:0] val_in;
    gfp2_pkg::word_t [3:0] acc_in;
    gfp2_pkg::word_t [3:0] acc_d;

    if (s == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign val_in = val_i;
      assign acc_in = '0;
    end else begin : g_next
      assign ctl_in = ctl_q[s-1];
      assign val_in = val_q[s-1];
      assign acc_in = acc_q[s-1];
    end

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        logic [W+1:0] sum;
        logic [W+1:0] m1;
        logic [W+1:0] m2;
        m1  = {2'b00, mod_i};
        m2  = {1'b0, mod_i, 1'b0};
        sum = {1'b0, acc_in[l], 1'b0}
            + {2'b00, val_in[LA[l]] & {W{val_in[LB[l]][W-1-s]}}};
        if (sum >= m2) begin
          acc_d[l] = W'(sum - m2);
        end else if (sum >= m1) begin
          acc_d[l] = W'(sum - m1);
        end else begin
          acc_d[l] = sum[W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '{valid: 1'b0, op: gfp2_pkg::OP_ADD};
      end else begin
        ctl_q[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      val_q[s]    <= val_in;
      acc_q[s]    <= acc_d;
    end
  end

  assign ctl_o  = ctl_q[W-1];
  assign val_o  = val_q[W-1];
  assign prod_o = acc_q[W-1];

endmodule
`default_nettype wire

@@ rtl/gfp2_combine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gfp2_combine
// Two-stage result forming: cross term and linear ops, then the final
// subtractions, opcode select and output register.
// ----------------------------------------------------------------------------
module gfp2_combine (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire gfp2_pkg::word_t             mod_i,
  input  wire gfp2_pkg::ctl_t              ctl_i,
  input  wire gfp2_pkg::word_t [3:0]       val_i,
  input  wire gfp2_pkg::word_t [3:0]       prod_i,
  output logic                             valid_o,
  output gfp2_pkg::word_t                  z_one_o,
  output gfp2_pkg::word_t                  z_two_o
);

  localparam int W = gfp2_pkg::WIDTH;

  function automatic gfp2_pkg::word_t add_m(gfp2_pkg::word_t a, gfp2_pkg::word_t b,
                                             gfp2_pkg::word_t m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  function automatic gfp2_pkg::word_t sub_m(gfp2_pkg::word_t a, gfp2_pkg::word_t b,
                                             gfp2_pkg::word_t m);
    if (a >= b) begin
      return a - b;
    end
    return a + (m - b);
  endfunction

  gfp2_pkg::ctl_t  ctl_q;
  gfp2_pkg::word_t t_q, p22_q, p11_q, n1_q, n2_q;
  gfp2_pkg::word_t n1_d, n2_d;
  gfp2_pkg::word_t z1_d, z2_d;
  gfp2_pkg::word_t z1_q, z2_q;
  logic            vld_q;

  always_comb begin
    n1_d = '0;
    n2_d = '0;
    case (ctl_i.op)
      gfp2_pkg::OP_ADD: begin
        n1_d = add_m(val_i[gfp2_pkg::IX1], val_i[gfp2_pkg::IY1], mod_i);
        n2_d = add_m(val_i[gfp2_pkg::IX2], val_i[gfp2_pkg::IY2], mod_i);
      end
      gfp2_pkg::OP_SUB: begin
        n1_d = sub_m(val_i[gfp2_pkg::IX1], val_i[gfp2_pkg::IY1], mod_i);
        n2_d = sub_m(val_i[gfp2_pkg::IX2], val_i[gfp2_pkg::IY2], mod_i);
      end
      gfp2_pkg::OP_FROB: begin
        n1_d = val_i[gfp2_pkg::IX2];
        n2_d = val_i[gfp2_pkg::IX1];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, op: gfp2_pkg::OP_ADD};
      vld_q <= 1'b0;
    end else begin
      ctl_q <= ctl_i;
      vld_q <= ctl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q      <= add_m(prod_i[0], prod_i[1], mod_i);
    p22_q    <= prod_i[2];
    p11_q    <= prod_i[3];
    n1_q     <= n1_d;
    n2_q     <= n2_d;
  end

  always_comb begin
    if (ctl_q.op == gfp2_pkg::OP_MUL || ctl_q.op == gfp2_pkg::OP_SQR) begin
      z1_d = sub_m(p22_q, t_q, mod_i);
      z2_d = sub_m(p11_q, t_q, mod_i);
    end else begin
      z1_d = n1_q;
      z2_d = n2_q;
    end
    if (mod_i == '0) begin
      z1_d = '0;
      z2_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    z1_q <= z1_d;
    z2_q <= z2_d;
  end

  assign valid_o = vld_q;
  assign z_one_o = z1_q;
  assign z_two_o = z2_q;

endmodule
`default_nettype wire

@@ rtl/gf_p2_field_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gf_p2_field_alu
// GF(p^2) arithmetic in the basis {a, a^2}: add, subtract, multiply, square
// and Frobenius, modulus p from a configuration register.
// ----------------------------------------------------------------------------
// Takes one operation every cycle; busy never rises. Each result appears on
// z_one_o/z_two_o with done_o high for one cycle, in issue order. The path
// is 2*WIDTH+2 register stages: WIDTH stages of bitwise operand reduction,
// WIDTH stages of double-and-add multiplication, then two combine stages.
// The receiver cannot stall. Write the modulus only when no operation is in
// flight.
module gf_p2_field_alu (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire gfp2_pkg::word_t cfg_wdata_i,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [2:0]      opcode_i,
  input  wire gfp2_pkg::word_t x_one_i,
  input  wire gfp2_pkg::word_t x_two_i,
  input  wire gfp2_pkg::word_t y_one_i,
  input  wire gfp2_pkg::word_t y_two_i,
  output logic                 done_o,
  output gfp2_pkg::word_t      z_one_o,
  output gfp2_pkg::word_t      z_two_o
);

  gfp2_pkg::word_t       mod_q;
  gfp2_pkg::ctl_t        in_ctl, red_ctl, mul_ctl;
  gfp2_pkg::word_t [3:0] in_val, red_val, sq_val, mul_val, mul_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= gfp2_pkg::WIDTH'(5);
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
    end
  end

  assign busy         = 1'b0;
  assign in_ctl.valid = start && !busy;
  assign in_ctl.op    = gfp2_pkg::op_e'(opcode_i);

  always_comb begin
    in_val                = '0;
    in_val[gfp2_pkg::IX1] = x_one_i;
    in_val[gfp2_pkg::IX2] = x_two_i;
    in_val[gfp2_pkg::IY1] = y_one_i;
    in_val[gfp2_pkg::IY2] = y_two_i;
  end

  gfp2_reduce u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mod_i  (mod_q),
    .ctl_i  (in_ctl),
    .val_i  (in_val),
    .ctl_o  (red_ctl),
    .res_o  (red_val)
  );

  always_comb begin
    sq_val = red_val;
    if (red_ctl.op == gfp2_pkg::OP_SQR) begin
      sq_val[gfp2_pkg::IY1] = red_val[gfp2_pkg::IX1];
      sq_val[gfp2_pkg::IY2] = red_val[gfp2_pkg::IX2];
    end
  end

  gfp2_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mod_i  (mod_q),
    .ctl_i  (red_ctl),
    .val_i  (sq_val),
    .ctl_o  (mul_ctl),
    .val_o  (mul_val),
    .prod_o (mul_prod)
  );

  gfp2_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mod_i   (mod_q),
    .ctl_i   (mul_ctl),
    .val_i   (mul_val),
    .prod_i  (mul_prod),
    .valid_o (done_o),
    .z_one_o (z_one_o),
    .z_two_o (z_two_o)
  );

endmodule
`default_nettype wire

@@ tb/tb_gf_p2_field_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_gf_p2_field_alu
// Self-checking bench for the GF(p^2) field ALU. Directed table rows, then
// random operations under several moduli, checked against a behavioral
// model of the field arithmetic. Results are matched in issue order.
// ----------------------------------------------------------------------------
module tb_gf_p2_field_alu;

  localparam int W = gfp2_pkg::WIDTH;
  localparam int LATENCY = 2*W+2;
  localparam logic [2:0] OP_BAD5 = 3'd5;
  localparam logic [2:0] OP_BAD7 = 3'd7;
  localparam gfp2_pkg::word_t ALL1 = {W{1'b1}};

  typedef struct {
    logic [2:0]      op;
    gfp2_pkg::word_t x1, x2, y1, y2;
  } field_op_t;

  typedef struct {
    gfp2_pkg::word_t z1, z2;
  } elem_t;

  typedef struct {
    logic            has_exp;
    logic [2:0]      op;
    gfp2_pkg::word_t x1, x2, y1, y2;
    gfp2_pkg::word_t z1, z2;
  } row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  gfp2_pkg::word_t cfg_wdata_i = '0;
  logic            start = 1'b0;
  logic            busy;
  logic [2:0]      opcode_i = '0;
  gfp2_pkg::word_t x_one_i = '0, x_two_i = '0, y_one_i = '0, y_two_i = '0;
  logic            done_o;
  gfp2_pkg::word_t z_one_o, z_two_o;

  gfp2_pkg::word_t modulus_q = W'(5);
  elem_t pending_z[$];
  int    errors = 0;
  bit    quiet = 1'b0;

  gf_p2_field_alu uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .start(start), .busy(busy), .opcode_i(opcode_i), .x_one_i(x_one_i),
    .x_two_i(x_two_i), .y_one_i(y_one_i), .y_two_i(y_two_i), .done_o(done_o),
    .z_one_o(z_one_o), .z_two_o(z_two_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50000000;
    $display("FAIL gf_p2_field_alu");
    $finish;
  end

  function automatic gfp2_pkg::word_t fadd(gfp2_pkg::word_t a, gfp2_pkg::word_t b,
                                           gfp2_pkg::word_t m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  function automatic gfp2_pkg::word_t fsub(gfp2_pkg::word_t a, gfp2_pkg::word_t b,
                                           gfp2_pkg::word_t m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, m} - {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  function automatic gfp2_pkg::word_t fmul(gfp2_pkg::word_t a, gfp2_pkg::word_t b,
                                           gfp2_pkg::word_t m);
    logic [2*W-1:0] p;
    p = {{W{1'b0}}, a} * {{W{1'b0}}, b};
    return W'(p % {{W{1'b0}}, m});
  endfunction

  function automatic elem_t field_result(field_op_t f, gfp2_pkg::word_t m);
    elem_t r;
    gfp2_pkg::word_t x1, x2, y1, y2, t;
    r = '{default: '0};
    if (m == '0) return r;
    x1 = f.x1 % m; x2 = f.x2 % m; y1 = f.y1 % m; y2 = f.y2 % m;
    if (f.op == gfp2_pkg::OP_SQR) begin
      y1 = x1; y2 = x2;
    end
    case (f.op)
      gfp2_pkg::OP_ADD: begin
        r.z1 = fadd(x1, y1, m); r.z2 = fadd(x2, y2, m);
      end
      gfp2_pkg::OP_SUB: begin
        r.z1 = fsub(x1, y1, m); r.z2 = fsub(x2, y2, m);
      end
      gfp2_pkg::OP_MUL, gfp2_pkg::OP_SQR: begin
        t = fadd(fmul(x1, y2, m), fmul(x2, y1, m), m);
        r.z1 = fsub(fmul(x2, y2, m), t, m);
        r.z2 = fsub(fmul(x1, y1, m), t, m);
      end
      gfp2_pkg::OP_FROB: begin
        r.z1 = x2; r.z2 = x1;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    elem_t e;
    if (done_o) begin
      if (pending_z.size() == 0) begin
        $display("%0t: unexpected result z1=%h z2=%h", $time, z_one_o, z_two_o);
        errors++;
      end else begin
        e = pending_z.pop_front();
        if (z_one_o !== e.z1) begin
          $display("%0t: z_one exp %h got %h", $time, e.z1, z_one_o);
          errors++;
        end
        if (z_two_o !== e.z2) begin
          $display("%0t: z_two exp %h got %h", $time, e.z2, z_two_o);
          errors++;
        end
      end
    end
  end

  task automatic set_modulus(gfp2_pkg::word_t m);
    while (pending_z.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    modulus_q = m;
  endtask

  // one transfer; expectation pushed at the accepting edge
  task automatic issue(field_op_t f, bit has_exp, elem_t e);
    int gap;
    if (!quiet && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= f.op;
    x_one_i <= f.x1; x_two_i <= f.x2; y_one_i <= f.y1; y_two_i <= f.y2;
    do @(posedge clk_i); while (busy);
    pending_z.push_back(has_exp ? e : field_result(f, modulus_q));
  endtask

  function automatic gfp2_pkg::word_t rand_word();
    gfp2_pkg::word_t w;
    w = W'({$urandom, $urandom});
    case ($urandom_range(5))
      0: w = '0;
      1: w = ALL1 - W'($urandom_range(3));
      2: w = W'($urandom_range(20));
      3: w = modulus_q - W'(1) + W'($urandom_range(2));
      default: ;
    endcase
    return w;
  endfunction

  function automatic field_op_t rand_op();
    field_op_t f;
    f.op = ($urandom_range(15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
    f.x1 = rand_word(); f.x2 = rand_word(); f.y1 = rand_word(); f.y2 = rand_word();
    return f;
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (pending_z.size() != 0) @(posedge clk_i);
  endtask

  row_t dir_rows[$];
  gfp2_pkg::word_t moduli[] = '{64'd7, 64'd1, 64'd0, 64'hFFFF_FFFF_FFFF_FFC5, ALL1, 64'd4,
                                64'd1_000_000_007, 64'hFFFF_FFFF_FFFF_FFC5};

  initial begin
    field_op_t f;
    elem_t     e;
    row_t      r;
    dir_rows = '{
      '{1'b1, gfp2_pkg::OP_ADD,  64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0},
      '{1'b1, gfp2_pkg::OP_ADD,  64'd4, 64'd3, 64'd1, 64'd4, 64'd0, 64'd2},
      '{1'b1, gfp2_pkg::OP_SUB,  64'd0, 64'd1, 64'd1, 64'd0, 64'd4, 64'd1},
      '{1'b1, gfp2_pkg::OP_FROB, 64'd1, 64'd3, 64'd0, 64'd0, 64'd3, 64'd1},
      '{1'b1, gfp2_pkg::OP_FROB, 64'd7, 64'd9, 64'd2, 64'd2, 64'd4, 64'd2},
      '{1'b1, OP_BAD5,           64'd1, 64'd2, 64'd3, 64'd4, 64'd0, 64'd0},
      '{1'b1, OP_BAD7,           ALL1,  ALL1,  ALL1,  ALL1,  64'd0, 64'd0},
      '{1'b1, gfp2_pkg::OP_MUL,  64'd0, 64'd0, ALL1,  ALL1,  64'd0, 64'd0},
      '{1'b0, gfp2_pkg::OP_MUL,  ALL1,  ALL1,  ALL1,  ALL1,  64'd0, 64'd0},
      '{1'b0, gfp2_pkg::OP_SQR,  ALL1,  64'd3, 64'd0, 64'd0, 64'd0, 64'd0},
      '{1'b0, gfp2_pkg::OP_SUB,  ALL1,  64'd0, 64'd0, ALL1,  64'd0, 64'd0},
      '{1'b0, gfp2_pkg::OP_ADD,  ALL1,  ALL1,  ALL1,  ALL1,  64'd0, 64'd0},
      '{1'b0, gfp2_pkg::OP_MUL,  64'd2, 64'd3, 64'd4, 64'd1, 64'd0, 64'd0},
      '{1'b0, 3'd6,              64'd2, 64'd3, 64'd4, 64'd1, 64'd0, 64'd0}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      f = '{r.op, r.x1, r.x2, r.y1, r.y2};
      e = '{r.z1, r.z2};
      issue(f, r.has_exp, e);
    end
    drain();
    foreach (moduli[k]) begin
      set_modulus(moduli[k]);
      if (k == 0) begin
        f = '{gfp2_pkg::OP_ADD, ALL1, 64'd0, 64'd0, 64'd0};
        issue(f, 1'b0, e);
      end
      if (k == moduli.size() - 1) quiet = 1'b1;
      repeat (75) begin
        f = rand_op();
        issue(f, 1'b0, e);
      end
      drain();
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && pending_z.size() == 0) begin
      $display("PASS gf_p2_field_alu");
    end else begin
      $display("FAIL gf_p2_field_alu");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/gfp2_pkg.sv
rtl/gfp2_reduce.sv
rtl/gfp2_mulmod.sv
rtl/gfp2_combine.sv
rtl/gf_p2_field_alu.sv
tb/tb_gf_p2_field_alu.sv
